/* src/smt_pkg.sv */
// shared types, constants and helpers of the stack map table parser
package smt_pkg;

  localparam int MAX_FUNCTIONS_DFLT = 256;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_CW = $clog2(RQ_DEPTH + 1);
  localparam int RQ_AW = $clog2(RQ_DEPTH);
  localparam logic [30:0] GUARD_LIMIT = 31'h4000_0000;
  localparam logic [30:0] HDR_MIN = 31'd20;
  localparam logic [7:0] VERSION = 8'd3;
  localparam int OUT_DW = 216;

  typedef enum logic [2:0] {
    K_RECORD    = 3'd0,
    K_LOCATION  = 3'd1,
    K_TABLE_END = 3'd2,
    K_SECT_END  = 3'd3,
    K_TRUNC     = 3'd4,
    K_TOO_MANY  = 3'd5
  } kind_t;

  typedef enum logic [11:0] {
    PH_HEADER   = 12'b0000_0000_0001,
    PH_FN_ADDR  = 12'b0000_0000_0010,
    PH_FN_SIZE  = 12'b0000_0000_0100,
    PH_FN_COUNT = 12'b0000_0000_1000,
    PH_CONST    = 12'b0000_0001_0000,
    PH_REC_HDR  = 12'b0000_0010_0000,
    PH_LOC      = 12'b0000_0100_0000,
    PH_LOC_PAD  = 12'b0000_1000_0000,
    PH_LIVE_HDR = 12'b0001_0000_0000,
    PH_LIVE     = 12'b0010_0000_0000,
    PH_REC_PAD  = 12'b0100_0000_0000,
    PH_STOPPED  = 12'b1000_0000_0000
  } ph_t;

  typedef enum logic [2:0] {
    C_IDLE      = 3'b001,
    C_PICK      = 3'b010,
    C_PICK_WAIT = 3'b100
  } ctl_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        ret_pc;
    logic [63:0]        pp_id;
    logic [15:0]        loc_count;
    logic [7:0]         loc_type;
    logic [15:0]        loc_size;
    logic [15:0]        loc_reg;
    logic signed [31:0] loc_offset;
    logic               last;
  } res_t;

  // bytes in one parse unit of each phase
  function automatic logic [4:0] unit_len(ph_t p);
    logic [4:0] n;
    unique case (p)
      PH_HEADER:   n = 5'd16;
      PH_FN_ADDR:  n = 5'd8;
      PH_FN_SIZE:  n = 5'd8;
      PH_FN_COUNT: n = 5'd8;
      PH_CONST:    n = 5'd8;
      PH_REC_HDR:  n = 5'd16;
      PH_LOC:      n = 5'd12;
      PH_LIVE_HDR: n = 5'd4;
      PH_LIVE:     n = 5'd4;
      default:     n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

/* src/smt_ram.sv */
// single-port-write, registered-read memory for the per-function tables
module smt_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/smt_res_q.sv */
// small result queue, up to two pushes and one pop per cycle
module smt_res_q (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                push_n,
  input  smt_pkg::res_t             push0,
  input  smt_pkg::res_t             push1,
  input  logic                      pop_ready,
  output logic                      pop_valid,
  output smt_pkg::res_t             pop_data,
  output logic [smt_pkg::RQ_CW-1:0] count
);
  import smt_pkg::*;

  res_t             ent_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_r, rd_r;
  logic [RQ_CW-1:0] cnt_r;
  logic             pop;
  logic [RQ_AW-1:0] wr1;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = ent_r[rd_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = cnt_r;
  assign wr1       = wr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      ent_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      ent_r[wr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + RQ_AW'(push_n);
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + RQ_CW'(push_n) - RQ_CW'(pop);
    end
  end

endmodule

/* src/stack_map_table_parser.sv */
// top level: byte-stream parser for version-3 stack map sections
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata: data_byte; tuser: first_byte
//  out_     out  out_tvalid/out_tready  tdata: result fields; tuser: kind; tlast
//  cfg_     in   cfg_valid/cfg_ready    cfg_data: section_length
//
// one byte is taken per cycle while no function walk runs and the result queue has
// room for two results; moving to the record section, and each record that finishes a
// function, walks the function tables: C_PICK looks up each function and C_PICK_WAIT
// takes its count memory read, and the walk ends in C_PICK past the last function
// reset is synchronous; the function tables hold no reset state and need no clearing
// a stalled result consumer backs up the queue and then in_tready drops
module stack_map_table_parser #(
  parameter int MAX_FUNCTIONS = smt_pkg::MAX_FUNCTIONS_DFLT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // data_byte
  input  logic                       in_tuser,   // first_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // return pc, statepoint id, location count, location type,
  // location size, location register, location offset
  output logic [smt_pkg::OUT_DW-1:0] out_tdata,
  output logic [2:0]                 out_tuser,  // kind
  output logic                       out_tlast,  // last_of_run
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [30:0]                cfg_data    // section_length
);
  import smt_pkg::*;

  localparam int AW = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
  localparam int CW = $clog2(MAX_FUNCTIONS + 1);
  localparam logic [31:0] MAXF = 32'(MAX_FUNCTIONS);

  logic [30:0] sect_len_r;
  ph_t         phase_r, phase_nxt;
  ctl_t        ctl_r, ctl_nxt;
  logic [30:0] pos_r, pos_nxt;
  logic [63:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] nfun_r, nfun_nxt, items_r, items_nxt, recs_r, recs_nxt;
  logic [15:0] sub_r, sub_nxt;
  logic [CW-1:0] cf_r, cf_nxt;
  logic [63:0] rem_r, rem_nxt, fn_addr_r, fn_addr_nxt;

  logic          in_acc;
  logic          addr_we, cnt_we;
  logic [63:0]   addr_rd, cnt_rd;
  logic [63:0]   wr_word;
  logic [1:0]    push_n;
  res_t          r0, r1;
  res_t          q_out;
  logic [RQ_CW-1:0] q_cnt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (ctl_r == C_IDLE) && (q_cnt <= RQ_CW'(RQ_DEPTH - 2));
  assign cfg_ready = 1'b1;

  // unit word with the byte of this transfer merged in
  always_comb begin
    wr_word = lo_r;
    wr_word[{idx_r[2:0], 3'b000} +: 8] = in_tdata;
  end

  smt_ram #(.DEPTH(MAX_FUNCTIONS), .AW(AW), .DW(64)) u_addr_ram (
    .clk(clk), .we(addr_we), .waddr(cf_r[AW-1:0]), .wdata(wr_word),
    .raddr(cf_r[AW-1:0]), .rdata(addr_rd)
  );

  smt_ram #(.DEPTH(MAX_FUNCTIONS), .AW(AW), .DW(64)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cf_r[AW-1:0]), .wdata(wr_word),
    .raddr(cf_r[AW-1:0]), .rdata(cnt_rd)
  );

  always_comb begin
    ph_t         ph;
    logic [30:0] pos, limit, nxt;
    logic [63:0] lo, hi;
    logic [3:0]  idx;
    logic [4:0]  idx5;
    logic [31:0] nfun, items, recs;
    logic [15:0] sub;
    logic [CW-1:0] cf;
    logic [63:0] rem;
    logic [36:0] fixed;
    logic        gc, gr, rdn, te, pk, pick;
    res_t        cand [4];
    logic [3:0]  cv;
    logic [1:0]  n;

    phase_nxt   = phase_r;
    ctl_nxt     = ctl_r;
    pos_nxt     = pos_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    idx_nxt     = idx_r;
    nfun_nxt    = nfun_r;
    items_nxt   = items_r;
    recs_nxt    = recs_r;
    sub_nxt     = sub_r;
    cf_nxt      = cf_r;
    rem_nxt     = rem_r;
    fn_addr_nxt = fn_addr_r;
    addr_we     = 1'b0;
    cnt_we      = 1'b0;
    push_n      = 2'd0;
    r0          = '0;
    r1          = '0;

    limit = (sect_len_r != '0) ? sect_len_r : GUARD_LIMIT;
    ph = phase_r; pos = pos_r; lo = lo_r; hi = hi_r; idx = idx_r;
    nfun = nfun_r; items = items_r; recs = recs_r; sub = sub_r;
    cf = cf_r; rem = rem_r;
    nxt = pos + 1'b1;
    idx5 = '0;
    fixed = '0;
    gc = 1'b0; gr = 1'b0; rdn = 1'b0; te = 1'b0; pk = 1'b0; pick = 1'b0;
    cv = '0;
    n = 2'd0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand[1].kind = K_TABLE_END;
    cand[2].kind = K_SECT_END;
    cand[3].kind = K_TRUNC;

    unique case (ctl_r)
      C_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            ph = PH_HEADER; pos = '0; lo = '0; hi = '0; idx = '0;
            nfun = '0; items = '0; recs = '0; sub = '0; cf = '0; rem = '0;
          end
          nxt = pos + 1'b1;
          if (!(pos >= limit || ph == PH_STOPPED)) begin
            if (ph == PH_HEADER && idx == '0 &&
                ((limit - pos) < HDR_MIN || in_tdata != VERSION)) begin
              cv[0] = 1'b1; cand[0].kind = K_SECT_END; ph = PH_STOPPED;
            end else begin
              if (!idx[3]) begin
                lo[{idx[2:0], 3'b000} +: 8] = in_tdata;
              end else begin
                hi[{idx[2:0], 3'b000} +: 8] = in_tdata;
              end
              // one bit wider so a 16-byte unit completes
              idx5 = {1'b0, idx} + 5'd1;
              idx = idx5[3:0];
              if (idx5 >= unit_len(ph)) begin
                idx = '0;
                unique case (ph)
                  PH_HEADER: begin
                    nfun  = lo[63:32];
                    items = hi[31:0];
                    recs  = hi[63:32];
                    // 24 per function plus 8 per constant
                    fixed = {1'b0, nfun, 4'b0000} + {2'b00, nfun, 3'b000}
                          + {2'b00, items, 3'b000};
                    if (fixed > {6'b0, limit - nxt}) begin
                      cv[0] = 1'b1; cand[0].kind = K_SECT_END; ph = PH_STOPPED;
                    end else if (nfun > MAXF) begin
                      cv[0] = 1'b1; cand[0].kind = K_TOO_MANY; ph = PH_STOPPED;
                    end else begin
                      cf = '0;
                      if (nfun != '0) ph = PH_FN_ADDR;
                      else gc = 1'b1;
                    end
                  end
                  PH_FN_ADDR: begin
                    addr_we = 1'b1;
                    ph = PH_FN_SIZE;
                  end
                  PH_FN_SIZE: ph = PH_FN_COUNT;
                  PH_FN_COUNT: begin
                    cnt_we = 1'b1;
                    cf = cf + 1'b1;
                    if ({{(32-CW){1'b0}}, cf} < nfun) ph = PH_FN_ADDR;
                    else gc = 1'b1;
                  end
                  PH_CONST: begin
                    items = items - 1'b1;
                    if (items == '0) gr = 1'b1;
                  end
                  PH_REC_HDR: begin
                    cv[0] = 1'b1;
                    cand[0].kind      = K_RECORD;
                    cand[0].ret_pc    = fn_addr_r + {32'b0, hi[31:0]};
                    cand[0].pp_id     = lo;
                    cand[0].loc_count = hi[63:48];
                    sub = hi[63:48];
                    if (sub != '0) ph = PH_LOC;
                    else ph = (nxt[2:0] != 3'd0) ? PH_LOC_PAD : PH_LIVE_HDR;
                  end
                  PH_LOC: begin
                    cv[0] = 1'b1;
                    cand[0].kind       = K_LOCATION;
                    cand[0].loc_type   = lo[7:0];
                    cand[0].loc_size   = lo[31:16];
                    cand[0].loc_reg    = lo[47:32];
                    cand[0].loc_offset = hi[31:0];
                    sub = sub - 1'b1;
                    if (sub == '0) ph = (nxt[2:0] != 3'd0) ? PH_LOC_PAD : PH_LIVE_HDR;
                  end
                  PH_LOC_PAD: begin
                    if (nxt[2:0] == 3'd0) ph = PH_LIVE_HDR;
                  end
                  PH_LIVE_HDR: begin
                    sub = lo[31:16];
                    if (sub != '0) ph = PH_LIVE;
                    else if (nxt[2:0] != 3'd0) ph = PH_REC_PAD;
                    else rdn = 1'b1;
                  end
                  PH_LIVE: begin
                    sub = sub - 1'b1;
                    if (sub == '0) begin
                      if (nxt[2:0] != 3'd0) ph = PH_REC_PAD;
                      else rdn = 1'b1;
                    end
                  end
                  PH_REC_PAD: begin
                    if (nxt[2:0] == 3'd0) rdn = 1'b1;
                  end
                  default: ph = ph;
                endcase
                if (gc) begin
                  if (items != '0) ph = PH_CONST;
                  else gr = 1'b1;
                end
                if (gr) begin
                  cf = '0;
                  if (recs != '0) begin
                    ph = PH_REC_HDR; pick = 1'b1;
                  end else begin
                    te = 1'b1;
                  end
                end
                if (rdn) begin
                  if (rem != '0) rem = rem - 1'b1;
                  if (rem == '0 && {{(32-CW){1'b0}}, cf} < nfun) begin
                    cf = cf + 1'b1; pk = 1'b1;
                  end
                  recs = recs - 1'b1;
                  if (recs != '0) begin
                    ph = PH_REC_HDR; pick = pk;
                  end else begin
                    te = 1'b1;
                  end
                end
                if (te) begin
                  cv[1] = 1'b1; ph = PH_HEADER;
                  if ((limit - nxt) < HDR_MIN) begin
                    cv[2] = 1'b1; ph = PH_STOPPED;
                  end
                end
                lo = '0;
                hi = '0;
              end
              if (ph != PH_STOPPED && nxt == limit) begin
                cv[3] = 1'b1; ph = PH_STOPPED; pick = 1'b0;
              end
            end
            pos = nxt;
          end
          for (int i = 0; i < 4; i++) begin
            if (cv[i]) begin
              if (n == 2'd0) r0 = cand[i];
              else if (n == 2'd1) r1 = cand[i];
              if (n != 2'd2) n = n + 1'b1;
            end
          end
          if (n == 2'd1) r0.last = 1'b1;
          if (n == 2'd2) r1.last = 1'b1;
          push_n = n;
          phase_nxt = ph; pos_nxt = pos; lo_nxt = lo; hi_nxt = hi; idx_nxt = idx;
          nfun_nxt = nfun; items_nxt = items; recs_nxt = recs; sub_nxt = sub;
          cf_nxt = cf; rem_nxt = rem;
          if (pick) ctl_nxt = C_PICK;
        end
      end
      C_PICK: begin
        if ({{(32-CW){1'b0}}, cf_r} < nfun_r) begin
          ctl_nxt = C_PICK_WAIT;
        end else begin
          rem_nxt = '0; fn_addr_nxt = '0; ctl_nxt = C_IDLE;
        end
      end
      C_PICK_WAIT: begin
        // functions without records are passed over
        if (cnt_rd == '0) begin
          cf_nxt = cf_r + 1'b1; ctl_nxt = C_PICK;
        end else begin
          rem_nxt = cnt_rd; fn_addr_nxt = addr_rd; ctl_nxt = C_IDLE;
        end
      end
      default: ctl_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sect_len_r <= '0;
      phase_r    <= PH_HEADER;
      ctl_r      <= C_IDLE;
      pos_r      <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
      idx_r      <= '0;
      nfun_r     <= '0;
      items_r    <= '0;
      recs_r     <= '0;
      sub_r      <= '0;
      cf_r       <= '0;
      rem_r      <= '0;
      fn_addr_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sect_len_r <= cfg_data;
      end
      phase_r   <= phase_nxt;
      ctl_r     <= ctl_nxt;
      pos_r     <= pos_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      idx_r     <= idx_nxt;
      nfun_r    <= nfun_nxt;
      items_r   <= items_nxt;
      recs_r    <= recs_nxt;
      sub_r     <= sub_nxt;
      cf_r      <= cf_nxt;
      rem_r     <= rem_nxt;
      fn_addr_r <= fn_addr_nxt;
    end
  end

  smt_res_q u_res_q (
    .clk(clk), .rst_n(rst_n), .push_n(push_n), .push0(r0), .push1(r1),
    .pop_ready(out_tready), .pop_valid(out_tvalid), .pop_data(q_out), .count(q_cnt)
  );

  assign out_tdata = {q_out.loc_offset, q_out.loc_reg, q_out.loc_size, q_out.loc_type,
                      q_out.loc_count, q_out.pp_id, q_out.ret_pc};
  assign out_tuser = q_out.kind;
  assign out_tlast = q_out.last;

  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> ({1'b0, q_cnt} + {1'b0, push_n} <= (RQ_CW + 1)'(RQ_DEPTH)))
    else $error("result queue overflow");

  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && phase_r == PH_STOPPED) |-> (push_n == 2'd0))
    else $error("result after section end");

  a_pick_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == C_PICK_WAIT) |-> ($past(ctl_r) == C_PICK))
    else $error("count read without lookup");

  a_pick_from_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r != C_IDLE) |-> (phase_r == PH_REC_HDR))
    else $error("function walk outside record phase");

endmodule
